// ===== rtl/gop_boundary_tracker_assert.svh =====
// Assertion macros for the GOP boundary tracker.
// Every macro samples on aclk and is held off while aresetn is low.
`ifndef GOP_BOUNDARY_TRACKER_ASSERT_SVH
`define GOP_BOUNDARY_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gbt_pkg.sv =====
// ----------------------------------------------------------------------------
// gbt_pkg
// Types, field widths, codes and helper functions shared by the GOP boundary
// tracker modules.
// ----------------------------------------------------------------------------
package gbt_pkg;

    localparam int TIME_W      = 40;
    localparam int SIZE_W      = 32;
    localparam int STREAM_W    = 8;
    localparam int KIND_W      = 3;
    localparam int GROUP_W     = 24;
    localparam int COUNT_W     = 32;
    localparam int BYTES_W     = 48;
    localparam int FLAG_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    // Request codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // Record codes.
    localparam logic REC_GROUP  = 1'b0;
    localparam logic REC_TOTALS = 1'b1;

    // Frame type codes.
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_I       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SI      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_P       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SP      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_B       = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BI      = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD    = 3'd7;

    // Bit positions in flag_bits.
    localparam int FLAG_CLOSED   = 0;
    localparam int FLAG_COMPLETE = 1;
    localparam int FLAG_KNOWN    = 2;
    localparam int FLAG_LAST     = 3;

    typedef enum logic [1:0] {
        CLS_INTRA,
        CLS_PRED,
        CLS_BIDIR,
        CLS_UNKNOWN
    } gbt_cls_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_TOTALS
    } gbt_back_state_t;

    typedef struct packed {
        logic                req_type;
        logic [STREAM_W-1:0] stream_id;
        logic [TIME_W-1:0]   time_stamp;
        logic                time_valid;
        logic [SIZE_W-1:0]   frame_bytes;
        logic [KIND_W-1:0]   frame_kind;
        logic                key_flag;
    } gbt_in_t;

    typedef struct packed {
        logic               rec_kind;
        logic [GROUP_W-1:0] group_number;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  end_time;
        logic [COUNT_W-1:0] frames_seen;
        logic [BYTES_W-1:0] bytes_seen;
        logic [COUNT_W-1:0] intra_count;
        logic [COUNT_W-1:0] pred_count;
        logic [COUNT_W-1:0] bidir_count;
        logic [SIZE_W-1:0]  largest_frame;
        logic [SIZE_W-1:0]  largest_intra;
        logic [FLAG_W-1:0]  flag_bits;
    } gbt_out_t;

    // One classified command passed from the front end to the back end.
    // For a finish command the time field carries the last clamped time.
    typedef struct packed {
        logic              is_finish;
        logic [TIME_W-1:0] time_val;
        logic [SIZE_W-1:0] size;
        gbt_cls_t          cls;
        logic              kind_known;
        logic              key;
    } gbt_cmd_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [BYTES_W-1:0] sat_add_bytes(input logic [BYTES_W-1:0] v,
                                                         input logic [SIZE_W-1:0]  d);
        logic [BYTES_W:0] s;
        s = {1'b0, v} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, d};
        return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
    endfunction

endpackage

// ===== rtl/gbt_front.sv =====
// ----------------------------------------------------------------------------
// gbt_front
// Accepts request beats, keeps timestamps monotonic, locks onto the first
// stream and classifies frames into commands for the back end.
// ----------------------------------------------------------------------------
module gbt_front
    import gbt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gbt_in_t  s_data,
    output logic     q_push,
    output gbt_cmd_t q_data,
    input  logic     q_full
);

    logic                done_reg, done_next;
    logic                locked_reg, locked_next;
    logic [STREAM_W-1:0] tracked_reg, tracked_next;
    logic [TIME_W-1:0]   prev_time_reg, prev_time_next;

    logic [TIME_W-1:0]   t_in;
    logic [TIME_W-1:0]   t_clamped;
    logic [KIND_W-1:0]   kind_eff;
    gbt_cls_t            cls;
    logic                stream_match;
    logic                accept;
    logic                is_finish;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign is_finish = (s_data.req_type == REQ_FINISH);

    // The previous time resets to zero, so a missing time before any sample
    // reads as zero and the clamp never raises the first time.
    always_comb begin
        t_in      = s_data.time_valid ? s_data.time_stamp : prev_time_reg;
        t_clamped = (t_in < prev_time_reg) ? prev_time_reg : t_in;
    end

    always_comb begin
        kind_eff = (s_data.frame_kind == KIND_RSVD) ? KIND_UNKNOWN : s_data.frame_kind;
        if (s_data.key_flag && (kind_eff == KIND_UNKNOWN)) begin
            kind_eff = KIND_I;
        end
        case (kind_eff) inside
            KIND_I, KIND_SI: cls = CLS_INTRA;
            KIND_P, KIND_SP: cls = CLS_PRED;
            KIND_B, KIND_BI: cls = CLS_BIDIR;
            default:         cls = CLS_UNKNOWN;
        endcase
    end

    assign stream_match = !locked_reg || (s_data.stream_id == tracked_reg);

    always_comb begin
        q_push             = accept && !done_reg && (is_finish || stream_match);
        q_data.is_finish   = is_finish;
        q_data.time_val    = is_finish ? prev_time_reg : t_clamped;
        q_data.size        = s_data.frame_bytes;
        q_data.cls         = cls;
        q_data.kind_known  = (kind_eff != KIND_UNKNOWN);
        q_data.key         = s_data.key_flag;
    end

    always_comb begin
        done_next      = done_reg;
        locked_next    = locked_reg;
        tracked_next   = tracked_reg;
        prev_time_next = prev_time_reg;
        if (accept && !done_reg) begin
            if (is_finish) begin
                done_next = 1'b1;
            end else begin
                prev_time_next = t_clamped;
                if (!locked_reg) begin
                    locked_next  = 1'b1;
                    tracked_next = s_data.stream_id;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= 1'b0;
            locked_reg    <= 1'b0;
            tracked_reg   <= '0;
            prev_time_reg <= '0;
        end else begin
            done_reg      <= done_next;
            locked_reg    <= locked_next;
            tracked_reg   <= tracked_next;
            prev_time_reg <= prev_time_next;
        end
    end

endmodule

// ===== rtl/gbt_fifo.sv =====
// ----------------------------------------------------------------------------
// gbt_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gbt_fifo
    import gbt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  gbt_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output gbt_cmd_t pop_data,
    output logic     not_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    gbt_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/gbt_div.sv =====
// ----------------------------------------------------------------------------
// gbt_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbt_div
    import gbt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [TIME_W-1:0]  dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [TIME_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [TIME_W-1:0]  quot_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               fits;

    // The remainder stays below the divisor, so the shifted trial value
    // needs one bit more than the divisor.
    always_comb begin
        trial = {rem_reg, quot_reg[TIME_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TIME_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[TIME_W-2:0], fits};
            rem_reg  <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        end
    end

endmodule

// ===== rtl/gbt_back.sv =====
// ----------------------------------------------------------------------------
// gbt_back
// Executes classified commands: keeps the open group and the stream totals,
// closes groups and drives the result register.
// ----------------------------------------------------------------------------
module gbt_back
    import gbt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cmd_valid,
    input  gbt_cmd_t cmd,
    output logic     cmd_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output gbt_out_t m_data
);

    gbt_back_state_t    state_reg, state_next;

    // Open group.
    logic               open_reg, open_next;
    logic               closed_reg, closed_next;
    logic               known_reg, known_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [COUNT_W-1:0] g_frames_reg, g_frames_next;
    logic [BYTES_W-1:0] g_bytes_reg, g_bytes_next;
    logic [COUNT_W-1:0] g_intra_reg, g_intra_next;
    logic [COUNT_W-1:0] g_pred_reg, g_pred_next;
    logic [COUNT_W-1:0] g_bidir_reg, g_bidir_next;
    logic [SIZE_W-1:0]  g_largest_reg, g_largest_next;
    logic [SIZE_W-1:0]  g_lintra_reg, g_lintra_next;

    // Stream totals.
    logic [TIME_W-1:0]  first_time_reg, first_time_next;
    logic [COUNT_W-1:0] samples_reg, samples_next;
    logic [COUNT_W-1:0] t_frames_reg, t_frames_next;
    logic [BYTES_W-1:0] t_bytes_reg, t_bytes_next;
    logic [COUNT_W-1:0] t_intra_reg, t_intra_next;
    logic [COUNT_W-1:0] t_pred_reg, t_pred_next;
    logic [COUNT_W-1:0] t_bidir_reg, t_bidir_next;
    logic [GROUP_W-1:0] groups_reg, groups_next;
    logic [TIME_W-1:0]  fin_time_reg, fin_time_next;

    logic               out_valid_reg, out_valid_next;
    gbt_out_t           out_data_reg, out_data_next;

    logic               slot_free;
    logic               needs_close;
    logic               emit;
    logic               div_start;
    logic               div_done;
    logic [TIME_W-1:0]  quotient;
    logic [TIME_W-1:0]  interval;
    logic [TIME_W:0]    end_sum;
    logic [TIME_W-1:0]  grp_end;
    logic [TIME_W-1:0]  grp_end_clamped;
    logic               base_zero;
    logic [COUNT_W+1:0] known_sum;
    gbt_out_t           group_rec;
    gbt_out_t           totals_rec;

    gbt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cmd.time_val - first_time_reg),
        .divisor  (samples_reg - 1'b1),
        .done     (div_done),
        .quotient (quotient)
    );

    assign slot_free   = !out_valid_reg || m_ready;
    assign needs_close = cmd.key && open_reg;
    assign m_valid     = out_valid_reg;
    assign m_data      = out_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && cmd.is_finish) begin
                    state_next = open_reg ? BK_DIVIDE : BK_TOTALS;
                end
            end
            BK_DIVIDE: begin
                if (div_done && slot_free) begin
                    state_next = BK_TOTALS;
                end
            end
            BK_TOTALS: begin
                if (slot_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        cmd_pop   = 1'b0;
        emit      = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.is_finish) begin
                        cmd_pop   = 1'b1;
                        div_start = open_reg;
                    end else if (!needs_close || slot_free) begin
                        cmd_pop = 1'b1;
                        emit    = needs_close;
                    end
                end
            end
            BK_DIVIDE: emit = div_done && slot_free;
            BK_TOTALS: emit = slot_free;
            default: begin
                cmd_pop   = 1'b0;
                emit      = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // End time of a closing group: the keyframe time, or for the last group
    // the last time plus the mean frame interval, saturated.
    always_comb begin
        interval        = (samples_reg > COUNT_W'(1)) ? quotient : '0;
        end_sum         = {1'b0, fin_time_reg} + {1'b0, interval};
        grp_end         = (state_reg == BK_DIVIDE)
                          ? (end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0])
                          : cmd.time_val;
        grp_end_clamped = (grp_end < start_reg) ? start_reg : grp_end;
    end

    always_comb begin
        group_rec.rec_kind      = REC_GROUP;
        group_rec.group_number  = groups_reg;
        group_rec.start_time    = start_reg;
        group_rec.end_time      = grp_end_clamped;
        group_rec.frames_seen   = g_frames_reg;
        group_rec.bytes_seen    = g_bytes_reg;
        group_rec.intra_count   = g_intra_reg;
        group_rec.pred_count    = g_pred_reg;
        group_rec.bidir_count   = g_bidir_reg;
        group_rec.largest_frame = g_largest_reg;
        group_rec.largest_intra = g_lintra_reg;
        group_rec.flag_bits                = '0;
        group_rec.flag_bits[FLAG_CLOSED]   = closed_reg;
        group_rec.flag_bits[FLAG_COMPLETE] = (state_reg == BK_IDLE);
        group_rec.flag_bits[FLAG_KNOWN]    = known_reg;
    end

    always_comb begin
        known_sum = {2'b00, t_intra_reg} + {2'b00, t_pred_reg} + {2'b00, t_bidir_reg};
        totals_rec.rec_kind      = REC_TOTALS;
        totals_rec.group_number  = groups_reg;
        totals_rec.start_time    = '0;
        totals_rec.end_time      = '0;
        totals_rec.frames_seen   = t_frames_reg;
        totals_rec.bytes_seen    = t_bytes_reg;
        totals_rec.intra_count   = t_intra_reg;
        totals_rec.pred_count    = t_pred_reg;
        totals_rec.bidir_count   = t_bidir_reg;
        totals_rec.largest_frame = '0;
        totals_rec.largest_intra = '0;
        totals_rec.flag_bits             = '0;
        totals_rec.flag_bits[FLAG_LAST]  = 1'b1;
        totals_rec.flag_bits[FLAG_KNOWN] =
            ({known_sum, 1'b0} > {3'b000, t_frames_reg});
    end

    // Result register.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = (state_reg == BK_TOTALS) ? totals_rec : group_rec;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Group, totals and counter updates.
    always_comb begin
        base_zero       = cmd.key || !open_reg;
        open_next       = open_reg;
        closed_next     = closed_reg;
        known_next      = known_reg;
        start_next      = start_reg;
        g_frames_next   = g_frames_reg;
        g_bytes_next    = g_bytes_reg;
        g_intra_next    = g_intra_reg;
        g_pred_next     = g_pred_reg;
        g_bidir_next    = g_bidir_reg;
        g_largest_next  = g_largest_reg;
        g_lintra_next   = g_lintra_reg;
        first_time_next = first_time_reg;
        samples_next    = samples_reg;
        t_frames_next   = t_frames_reg;
        t_bytes_next    = t_bytes_reg;
        t_intra_next    = t_intra_reg;
        t_pred_next     = t_pred_reg;
        t_bidir_next    = t_bidir_reg;
        groups_next     = groups_reg;
        fin_time_next   = fin_time_reg;

        if (emit && (state_reg != BK_TOTALS)) begin
            groups_next = (&groups_reg) ? groups_reg : groups_reg + 1'b1;
            open_next   = 1'b0;
        end

        if (cmd_pop && cmd.is_finish) begin
            fin_time_next = cmd.time_val;
        end

        if (cmd_pop && !cmd.is_finish) begin
            if (samples_reg == '0) begin
                first_time_next = cmd.time_val;
            end
            samples_next  = sat_inc(samples_reg);
            t_frames_next = sat_inc(t_frames_reg);
            t_bytes_next  = sat_add_bytes(t_bytes_reg, cmd.size);
            if (cmd.cls == CLS_INTRA) begin
                t_intra_next = sat_inc(t_intra_reg);
            end
            if (cmd.cls == CLS_PRED) begin
                t_pred_next = sat_inc(t_pred_reg);
            end
            if (cmd.cls == CLS_BIDIR) begin
                t_bidir_next = sat_inc(t_bidir_reg);
            end

            // A keyframe, or a sample with no group open, starts a fresh
            // group that this sample is the first member of.
            open_next     = 1'b1;
            start_next    = base_zero ? cmd.time_val : start_reg;
            closed_next   = cmd.key ? 1'b1 : (open_reg ? closed_reg : 1'b0);
            known_next    = (base_zero ? 1'b0 : known_reg) | cmd.kind_known;
            g_frames_next = sat_inc(base_zero ? '0 : g_frames_reg);
            g_bytes_next  = sat_add_bytes(base_zero ? '0 : g_bytes_reg, cmd.size);
            g_intra_next  = base_zero ? '0 : g_intra_reg;
            g_pred_next   = base_zero ? '0 : g_pred_reg;
            g_bidir_next  = base_zero ? '0 : g_bidir_reg;
            g_largest_next = base_zero ? '0 : g_largest_reg;
            g_lintra_next  = base_zero ? '0 : g_lintra_reg;
            if (cmd.cls == CLS_INTRA) begin
                g_intra_next = sat_inc(g_intra_next);
                if (cmd.size > g_lintra_next) begin
                    g_lintra_next = cmd.size;
                end
            end
            if (cmd.cls == CLS_PRED) begin
                g_pred_next = sat_inc(g_pred_next);
            end
            if (cmd.cls == CLS_BIDIR) begin
                g_bidir_next = sat_inc(g_bidir_next);
            end
            if (cmd.size > g_largest_next) begin
                g_largest_next = cmd.size;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            open_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            first_time_reg <= '0;
            samples_reg    <= '0;
            t_frames_reg   <= '0;
            t_bytes_reg    <= '0;
            t_intra_reg    <= '0;
            t_pred_reg     <= '0;
            t_bidir_reg    <= '0;
            groups_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            open_reg       <= open_next;
            out_valid_reg  <= out_valid_next;
            first_time_reg <= first_time_next;
            samples_reg    <= samples_next;
            t_frames_reg   <= t_frames_next;
            t_bytes_reg    <= t_bytes_next;
            t_intra_reg    <= t_intra_next;
            t_pred_reg     <= t_pred_next;
            t_bidir_reg    <= t_bidir_next;
            groups_reg     <= groups_next;
        end
    end

    // Group contents are only read while a group is open, and opening one
    // loads them, so they carry no reset.
    always_ff @(posedge aclk) begin
        closed_reg    <= closed_next;
        known_reg     <= known_next;
        start_reg     <= start_next;
        g_frames_reg  <= g_frames_next;
        g_bytes_reg   <= g_bytes_next;
        g_intra_reg   <= g_intra_next;
        g_pred_reg    <= g_pred_next;
        g_bidir_reg   <= g_bidir_next;
        g_largest_reg <= g_largest_next;
        g_lintra_reg  <= g_lintra_next;
        fin_time_reg  <= fin_time_next;
        out_data_reg  <= out_data_next;
    end

endmodule

// ===== rtl/gop_boundary_tracker.sv =====
// A closing keyframe passes the command queue and then the result register to m_valid.
// Throughput: one frame beat per cycle while the result side keeps up.
// A finish beat with a group open waits for the bit-serial divider to find the mean frame
// interval before its group record; the totals record follows it.
// Reset: aresetn is synchronous, active low, and clears control state and totals at once.
// ----------------------------------------------------------------------------
// gop_boundary_tracker
// Tracks group-of-pictures boundaries on one stream and reports per-group
// and whole-stream frame statistics.
// ----------------------------------------------------------------------------
`include "gop_boundary_tracker_assert.svh"

module gop_boundary_tracker
    import gbt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gbt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output gbt_out_t m_data
);

    // The front end takes a beat whenever the command queue has room. It
    // clamps the timestamp so that time never runs backwards, locks onto the
    // stream of the first frame beat and drops beats of other streams (their
    // timestamps still move the clamp). After a finish beat it drops every
    // further beat until reset.
    //
    // The back end pops one command per cycle while it is idle. A keyframe
    // that closes an open group also needs the result register free and waits
    // for it; every other frame is absorbed without a result. A finish command
    // starts the divider for the mean frame interval when a group is open,
    // emits that group as incomplete and then emits the stream totals.

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;
    gbt_cmd_t q_in;
    gbt_cmd_t q_out;

    gbt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_data  (q_in),
        .q_full  (q_full)
    );

    gbt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    gbt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_not_empty),
        .cmd       (q_out),
        .cmd_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // The front end must never push into a full queue.
    `GBT_ASSERT_SAME(a_no_push_when_full, q_push, !q_full, "command pushed into full queue")

    // The last-of-run flag marks the totals record and only that record.
    `GBT_ASSERT_SAME(a_last_flag_on_totals, m_valid,
        (m_data.rec_kind == REC_TOTALS) == m_data.flag_bits[FLAG_LAST],
        "last-of-run flag does not match record kind")

    // A group never ends before it starts.
    `GBT_ASSERT_SAME(a_group_end_order, m_valid && (m_data.rec_kind == REC_GROUP),
        m_data.end_time >= m_data.start_time, "group end time below start time")

    // Once the totals beat has gone, nothing else follows.
    `GBT_ASSERT_NEXT(a_quiet_after_totals,
        m_valid && m_ready && (m_data.rec_kind == REC_TOTALS), !m_valid,
        "result beat after the totals record")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GOP boundary tracker. A behavioural tracker
// inside the bench follows every accepted input beat and queues the records
// the block should produce. Every record beat is compared field by field
// with the oldest queued record. Directed tests cover stream locking,
// timestamp clamping, every frame type and a group of maximum-size frames.
// Random GOP sequences make up most of the run; the finish request ends it,
// and the beats sent after it must be ignored.
// ----------------------------------------------------------------------------
module tb_top;
    import gbt_pkg::*;

    // A generous bound for a correct run of about 600 beats, even with the
    // sender's longest gaps and the slowest receiver.
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_BEATS = 520;
    // A short group of maximum-size frames.
    localparam int FILL_BEATS   = 16;
    // The finish request runs a bit-serial divider before its records appear.
    localparam int DRAIN_CYCLES = 200;

    localparam logic [TIME_W-1:0]  TIME_TOP  = {TIME_W{1'b1}};
    localparam logic [BYTES_W-1:0] BYTES_TOP = {BYTES_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_TOP  = {SIZE_W{1'b1}};

    // Receiver behaviour; each mode lasts for a random stretch of cycles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_ALTERNATE
    } rx_mode_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    gbt_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    gbt_out_t m_data;

    gop_boundary_tracker u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioural tracker state. It mirrors the block's registers and is
    // advanced once for every beat that the block accepts.
    // ------------------------------------------------------------------------
    logic                run_done;
    logic                locked;
    logic [STREAM_W-1:0] lock_id;
    logic [TIME_W-1:0]   last_time;
    logic                last_time_ok;
    logic [TIME_W-1:0]   first_time;
    logic [COUNT_W-1:0]  sample_cnt;
    logic                grp_open;
    logic [TIME_W-1:0]   grp_start;
    logic                grp_closed;
    logic                grp_known;
    logic [COUNT_W-1:0]  grp_frames;
    logic [BYTES_W-1:0]  grp_bytes;
    logic [COUNT_W-1:0]  grp_cls_cnt [4];
    logic [SIZE_W-1:0]   grp_max;
    logic [SIZE_W-1:0]   grp_max_intra;
    logic [COUNT_W-1:0]  tot_frames;
    logic [BYTES_W-1:0]  tot_bytes;
    logic [COUNT_W-1:0]  tot_cls_cnt [4];
    logic [GROUP_W-1:0]  grp_index;

    // Records the block still owes us, oldest first.
    gbt_out_t records_due [$];

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // Sender pacing: bursts of back-to-back beats separated by random gaps.
    logic sender_idle = 1'b1;
    int   burst_left  = 0;

    // Stimulus-side timestamp, at or ahead of the block's last time in the kinds, random and fill tests.
    logic [TIME_W-1:0]   stim_clock = '0;
    logic [STREAM_W-1:0] tracked_id;

    // ------------------------------------------------------------------------
    // Saturating arithmetic at the block's widths.
    // ------------------------------------------------------------------------
    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [BYTES_W-1:0] grow_bytes(input logic [BYTES_W-1:0] v,
                                                      input logic [SIZE_W-1:0]  d);
        logic [BYTES_W-1:0] room;
        room = BYTES_TOP - v;
        return (BYTES_W'(d) > room) ? BYTES_TOP : v + BYTES_W'(d);
    endfunction

    function automatic logic [TIME_W-1:0] stretch_time(input logic [TIME_W-1:0] t,
                                                       input logic [TIME_W-1:0] d);
        return (d > TIME_TOP - t) ? TIME_TOP : t + d;
    endfunction

    task automatic reset_tracker();
        run_done      = 1'b0;
        locked        = 1'b0;
        lock_id       = '0;
        last_time     = '0;
        last_time_ok  = 1'b0;
        first_time    = '0;
        sample_cnt    = '0;
        grp_open      = 1'b0;
        grp_start     = '0;
        grp_closed    = 1'b0;
        grp_known     = 1'b0;
        grp_frames    = '0;
        grp_bytes     = '0;
        grp_max       = '0;
        grp_max_intra = '0;
        tot_frames    = '0;
        tot_bytes     = '0;
        grp_index     = '0;
        for (int c = 0; c < 4; c++) begin
            grp_cls_cnt[c] = '0;
            tot_cls_cnt[c] = '0;
        end
    endtask

    task automatic open_group(input logic [TIME_W-1:0] t, input logic closed);
        grp_open      = 1'b1;
        grp_start     = t;
        grp_closed    = closed;
        grp_known     = 1'b0;
        grp_frames    = '0;
        grp_bytes     = '0;
        grp_max       = '0;
        grp_max_intra = '0;
        for (int c = 0; c < 4; c++) begin
            grp_cls_cnt[c] = '0;
        end
    endtask

    // Queue the record of the open group and count it as closed.
    task automatic emit_group(input logic [TIME_W-1:0] end_t, input logic complete);
        gbt_out_t r;
        r = '0;
        r.rec_kind      = REC_GROUP;
        r.group_number  = grp_index;
        r.start_time    = grp_start;
        r.end_time      = (end_t < grp_start) ? grp_start : end_t;
        r.frames_seen   = grp_frames;
        r.bytes_seen    = grp_bytes;
        r.intra_count   = grp_cls_cnt[CLS_INTRA];
        r.pred_count    = grp_cls_cnt[CLS_PRED];
        r.bidir_count   = grp_cls_cnt[CLS_BIDIR];
        r.largest_frame = grp_max;
        r.largest_intra = grp_max_intra;
        r.flag_bits[FLAG_CLOSED]   = grp_closed;
        r.flag_bits[FLAG_COMPLETE] = complete;
        r.flag_bits[FLAG_KNOWN]    = grp_known;
        records_due = {records_due, r};
        if (grp_index != {GROUP_W{1'b1}}) begin
            grp_index = grp_index + 1'b1;
        end
        grp_open = 1'b0;
    endtask

    // Finish: the open group is closed as incomplete, with its end pushed out
    // by the mean frame interval, and then the stream totals follow.
    task automatic close_run();
        logic [TIME_W-1:0]  interval;
        logic [COUNT_W-1:0] steps;
        logic [COUNT_W+2:0] known;
        gbt_out_t           r;
        if (grp_open) begin
            interval = '0;
            if (sample_cnt > 1 && last_time >= first_time) begin
                steps    = sample_cnt - 1'b1;
                interval = (last_time - first_time) / TIME_W'(steps);
            end
            emit_group(stretch_time(last_time, interval), 1'b0);
        end
        known = (COUNT_W+3)'(tot_cls_cnt[CLS_INTRA]) + (COUNT_W+3)'(tot_cls_cnt[CLS_PRED])
              + (COUNT_W+3)'(tot_cls_cnt[CLS_BIDIR]);
        r = '0;
        r.rec_kind     = REC_TOTALS;
        r.group_number = grp_index;
        r.frames_seen  = tot_frames;
        r.bytes_seen   = tot_bytes;
        r.intra_count  = tot_cls_cnt[CLS_INTRA];
        r.pred_count   = tot_cls_cnt[CLS_PRED];
        r.bidir_count  = tot_cls_cnt[CLS_BIDIR];
        r.flag_bits[FLAG_LAST]  = 1'b1;
        r.flag_bits[FLAG_KNOWN] = (tot_frames != 0) &&
                                  ((known << 1) > (COUNT_W+3)'(tot_frames));
        records_due = {records_due, r};
        run_done = 1'b1;
    endtask

    // Advance the tracker by one accepted beat.
    task automatic track_beat(input gbt_in_t b);
        logic [TIME_W-1:0] t;
        logic [KIND_W-1:0] kind;
        gbt_cls_t          cls;
        if (run_done) begin
            return;
        end
        if (b.req_type == REQ_FINISH) begin
            close_run();
            return;
        end

        // Timestamps are kept monotonic, whichever stream they belong to.
        t = b.time_valid ? b.time_stamp : (last_time_ok ? last_time : '0);
        if (last_time_ok && t < last_time) begin
            t = last_time;
        end
        last_time    = t;
        last_time_ok = 1'b1;

        if (!locked) begin
            locked  = 1'b1;
            lock_id = b.stream_id;
        end
        if (b.stream_id != lock_id) begin
            return;
        end

        // The reserved code counts as unknown, and an untyped keyframe as I.
        kind = b.frame_kind;
        if (kind == KIND_RSVD) begin
            kind = KIND_UNKNOWN;
        end
        if (b.key_flag && kind == KIND_UNKNOWN) begin
            kind = KIND_I;
        end
        case (kind)
            KIND_I, KIND_SI: cls = CLS_INTRA;
            KIND_P, KIND_SP: cls = CLS_PRED;
            KIND_B, KIND_BI: cls = CLS_BIDIR;
            default:         cls = CLS_UNKNOWN;
        endcase

        if (sample_cnt == 0) begin
            first_time = t;
        end
        sample_cnt       = bump(sample_cnt);
        tot_frames       = bump(tot_frames);
        tot_bytes        = grow_bytes(tot_bytes, b.frame_bytes);
        tot_cls_cnt[cls] = bump(tot_cls_cnt[cls]);

        if (b.key_flag) begin
            if (grp_open) begin
                emit_group(t, 1'b1);
            end
            open_group(t, 1'b1);
        end else if (!grp_open) begin
            open_group(t, 1'b0);
        end

        grp_frames       = bump(grp_frames);
        grp_bytes        = grow_bytes(grp_bytes, b.frame_bytes);
        grp_cls_cnt[cls] = bump(grp_cls_cnt[cls]);
        if (cls == CLS_INTRA && b.frame_bytes > grp_max_intra) begin
            grp_max_intra = b.frame_bytes;
        end
        if (kind != KIND_UNKNOWN) begin
            grp_known = 1'b1;
        end
        if (b.frame_bytes > grp_max) begin
            grp_max = b.frame_bytes;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic gbt_in_t sample_beat(input logic [STREAM_W-1:0] sid,
                                            input logic [TIME_W-1:0]   t,
                                            input logic                tv,
                                            input logic [SIZE_W-1:0]   nbytes,
                                            input logic [KIND_W-1:0]   kind,
                                            input logic                key);
        gbt_in_t b;
        b.req_type    = REQ_SAMPLE;
        b.stream_id   = sid;
        b.time_stamp  = t;
        b.time_valid  = tv;
        b.frame_bytes = nbytes;
        b.frame_kind  = kind;
        b.key_flag    = key;
        return b;
    endfunction

    function automatic logic [TIME_W-1:0] advance_clock();
        stim_clock = stim_clock + TIME_W'($urandom_range(0, 4000));
        return stim_clock;
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [STREAM_W-1:0] other_stream();
        logic [STREAM_W-1:0] sid;
        sid = STREAM_W'($urandom_range(0, 255));
        while (sid == tracked_id) begin
            sid = STREAM_W'($urandom_range(0, 255));
        end
        return sid;
    endfunction

    // Present one beat, hold it until the block takes it, then tell the
    // tracker. Handshake signals are read straight after the edge, so they
    // still carry the values that the edge itself sampled.
    task automatic send_beat(input gbt_in_t item);
        int gap;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        track_beat(item);
        if (sender_idle) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // The first sample locks the stream and, without a keyframe, opens a group
    // that is not closed. Foreign samples move the time base but nothing else;
    // missing and backward timestamps are clamped to the last time.
    task automatic test_lock_and_time();
        logic [STREAM_W-1:0] foreign;
        foreign = ~tracked_id;
        send_beat(sample_beat(tracked_id, '0, 1'b1, '0, KIND_UNKNOWN, 1'b0));
        send_beat(sample_beat(foreign, TIME_W'(5000), 1'b1, SIZE_TOP, KIND_I, 1'b0));
        send_beat(sample_beat(tracked_id, random_stamp(), 1'b0, SIZE_W'(1), KIND_P, 1'b0));
        send_beat(sample_beat(tracked_id, TIME_W'(100), 1'b1, SIZE_W'(700), KIND_B, 1'b0));
        send_beat(sample_beat(other_stream(), TIME_W'(6000), 1'b1, SIZE_TOP, KIND_I, 1'b1));
        // This keyframe closes the open group with the closed bit clear.
        send_beat(sample_beat(tracked_id, TIME_W'(9000), 1'b1, SIZE_TOP, KIND_I, 1'b1));
        stim_clock = TIME_W'(9000);
    endtask

    // Every kind code once, then a keyframe of unknown kind, a plain frame of reserved kind
    // and keyframes of reserved kind and of kind SI; the untyped keyframes count as I frames.
    task automatic test_frame_kinds();
        logic [KIND_W-1:0] kinds [8];
        kinds = '{KIND_UNKNOWN, KIND_I, KIND_SI, KIND_P, KIND_SP, KIND_B, KIND_BI, KIND_RSVD};
        for (int k = 0; k < 8; k++) begin
            send_beat(sample_beat(tracked_id, advance_clock(), 1'b1, SIZE_W'($urandom),
                                  kinds[k], 1'b0));
        end
        send_beat(sample_beat(tracked_id, advance_clock(), 1'b1, SIZE_W'(3), KIND_UNKNOWN, 1'b1));
        send_beat(sample_beat(tracked_id, advance_clock(), 1'b1, '0, KIND_RSVD, 1'b0));
        send_beat(sample_beat(tracked_id, advance_clock(), 1'b1, SIZE_TOP, KIND_RSVD, 1'b1));
        send_beat(sample_beat(tracked_id, advance_clock(), 1'b1, SIZE_W'(40), KIND_SI, 1'b1));
    endtask

    // Mostly well-formed GOPs: a keyframe and a run of P and B frames with
    // rising times, now and then a foreign sample in between. The rest is
    // noise: rising, missing or backward times, any kind, stray keyframes.
    task automatic test_random_gops();
        int                  sent;
        int                  gop_len;
        logic [KIND_W-1:0]   kind;
        logic [SIZE_W-1:0]   nbytes;
        logic [STREAM_W-1:0] sid;
        logic [TIME_W-1:0]   t;
        logic                tv;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 80) begin
                gop_len = $urandom_range(0, 14);
                for (int i = 0; i <= gop_len; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_beat(sample_beat(other_stream(), advance_clock(), 1'b1,
                                              SIZE_W'($urandom),
                                              KIND_W'($urandom_range(KIND_UNKNOWN, KIND_RSVD)),
                                              1'b0));
                    end
                    if (i == 0) begin
                        case ($urandom_range(0, 2))
                            0:       kind = KIND_I;
                            1:       kind = KIND_SI;
                            default: kind = KIND_UNKNOWN;
                        endcase
                        nbytes = SIZE_W'($urandom_range(20_000, 200_000));
                    end else begin
                        case ($urandom_range(0, 8))
                            0, 1:    kind = KIND_P;
                            2:       kind = KIND_SP;
                            3, 4:    kind = KIND_B;
                            5:       kind = KIND_BI;
                            6:       kind = KIND_UNKNOWN;
                            default: kind = KIND_P;
                        endcase
                        nbytes = SIZE_W'($urandom_range(0, 60_000));
                    end
                    send_beat(sample_beat(tracked_id, advance_clock(), 1'b1, nbytes, kind,
                                          i == 0));
                    sent++;
                end
            end else begin
                sid = ($urandom_range(0, 1) == 0) ? tracked_id : other_stream();
                case ($urandom_range(0, 2))
                    0: begin
                        t  = advance_clock();
                        tv = 1'b1;
                    end
                    1: begin
                        t  = random_stamp();
                        tv = 1'b0;
                    end
                    default: begin
                        t  = stim_clock - TIME_W'($urandom_range(0, 5000));
                        tv = 1'b1;
                    end
                endcase
                send_beat(sample_beat(sid, t, tv, SIZE_W'($urandom),
                                      KIND_W'($urandom_range(KIND_UNKNOWN, KIND_RSVD)),
                                      1'($urandom_range(0, 1))));
                if (sid == tracked_id) begin
                    sent++;
                end
            end
        end
        sender_idle = 1'b1;
    endtask

    // One group of maximum-size frames sent back to back, all but the first with
    // missing times; the closing keyframe reports the group.
    task automatic test_max_size_frames();
        sender_idle = 1'b0;
        send_beat(sample_beat(tracked_id, advance_clock(), 1'b1, SIZE_TOP, KIND_I, 1'b1));
        repeat (FILL_BEATS) begin
            send_beat(sample_beat(tracked_id, '0, 1'b0, SIZE_TOP, KIND_P, 1'b0));
        end
        send_beat(sample_beat(tracked_id, advance_clock(), 1'b1, SIZE_W'(9), KIND_I, 1'b1));
        sender_idle = 1'b1;
    endtask

    // Times are driven to the top of their range so that the stretched end
    // time of the last group saturates. Finish then closes that group and
    // sends the totals; anything after it is ignored. A finish with no group
    // open would need a run with no tracked sample at all before it.
    task automatic test_finish_and_after();
        gbt_in_t b;
        send_beat(sample_beat(tracked_id, {1'b1, (TIME_W-1)'({$urandom, $urandom})}, 1'b1,
                              SIZE_W'(500), KIND_B, 1'b0));
        send_beat(sample_beat(tracked_id, TIME_TOP, 1'b1, SIZE_W'(800), KIND_P, 1'b0));
        send_beat(sample_beat(tracked_id, '0, 1'b0, SIZE_W'(300), KIND_BI, 1'b0));
        b = sample_beat(STREAM_W'($urandom), random_stamp(), 1'($urandom_range(0, 1)),
                        SIZE_W'($urandom), KIND_W'($urandom_range(KIND_UNKNOWN, KIND_RSVD)),
                        1'($urandom_range(0, 1)));
        b.req_type = REQ_FINISH;
        send_beat(b);
        send_beat(sample_beat(tracked_id, TIME_TOP, 1'b1, SIZE_TOP, KIND_I, 1'b1));
        send_beat(b);
        send_beat(sample_beat(tracked_id, '0, 1'b0, SIZE_W'(5), KIND_P, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready follows a mode that changes after a random stretch,
    // from always ready down to one cycle in eight.
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    logic     rx_phase = 1'b0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 200);
        end else begin
            rx_left--;
        end
        rx_phase = ~rx_phase;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:   m_ready <= rx_phase;
        endcase
    end

    // ------------------------------------------------------------------------
    // Checker: each record beat is matched against the oldest queued record.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        gbt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (records_due.size() == 0) begin
                $error("record beat with none outstanding: 0x%0h", m_data);
                mismatches++;
            end else begin
                want = records_due.pop_front();
                check_field("rec_kind",      64'(want.rec_kind),      64'(m_data.rec_kind));
                check_field("group_number",  64'(want.group_number),  64'(m_data.group_number));
                check_field("start_time",    64'(want.start_time),    64'(m_data.start_time));
                check_field("end_time",      64'(want.end_time),      64'(m_data.end_time));
                check_field("frames_seen",   64'(want.frames_seen),   64'(m_data.frames_seen));
                check_field("bytes_seen",    64'(want.bytes_seen),    64'(m_data.bytes_seen));
                check_field("intra_count",   64'(want.intra_count),   64'(m_data.intra_count));
                check_field("pred_count",    64'(want.pred_count),    64'(m_data.pred_count));
                check_field("bidir_count",   64'(want.bidir_count),   64'(m_data.bidir_count));
                check_field("largest_frame", 64'(want.largest_frame), 64'(m_data.largest_frame));
                check_field("largest_intra", 64'(want.largest_intra), 64'(m_data.largest_intra));
                check_field("flag_bits",     64'(want.flag_bits),     64'(m_data.flag_bits));
            end
        end
    end

    // Watchdog: a hung handshake or a record that never arrives ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence. Reset is applied once, so the finish request must come
    // last: after it the block ignores everything until the next reset.
    // ------------------------------------------------------------------------
    initial begin
        reset_tracker();
        tracked_id = STREAM_W'($urandom_range(0, 255));
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_lock_and_time();
        test_frame_kinds();
        test_random_gops();
        test_max_size_frames();
        test_finish_and_after();

        s_valid <= 1'b0;
        while (records_due.size() != 0) begin
            @(posedge aclk);
        end
        // Let any stray record show itself before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
